FILE: hdl/kc3_pkg.sv
// Package for the 3x3 RGB convolution block: shared types and constants.
// Used by every file under hdl; depends on nothing.
package kc3_pkg;
    localparam int MAX_WIDTH = 2048;
    localparam int CHANS = 3;
    localparam int PIX_W = 24;
    localparam int ROW_W = 12;
    localparam int COL_W = 11;
    localparam int SUM_W = 20;
    localparam int KSUM_W = 12;
    localparam int HEIGHT_LIMIT = 4096;
    localparam logic [7:0] CLAMP_MAX = 8'd255;

    typedef enum logic [2:0] {
        REG_KTOP = 3'd0,
        REG_KMID = 3'd1,
        REG_KBOT = 3'd2,
        REG_WIDTH = 3'd3,
        REG_HEIGHT = 3'd4
    } t_reg_idx;

    // result sequencer of the top level
    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_READ = 2'd1,
        SEQ_EMIT = 2'd2
    } t_seq_st;

    // phases of one color lane
    typedef enum logic [1:0] {
        LANE_IDLE = 2'd0,
        LANE_SUM = 2'd1,
        LANE_SETUP = 2'd2,
        LANE_DIV = 2'd3
    } t_lane_ph;

    typedef logic signed [7:0] t_coef;
    typedef t_coef t_kernel [9];

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic last_in_run;
        logic last_of_frame;
    } t_tag;
endpackage

FILE: hdl/kc3_if.sv
// Valid/ready channel interfaces for the convolution block.
// Depends on kc3_pkg.
interface kc3_pix_if;
    logic valid;
    logic ready;
    logic [7:0] chan_0;
    logic [7:0] chan_1;
    logic [7:0] chan_2;
    modport source (output valid, chan_0, chan_1, chan_2, input ready);
    modport sink (input valid, chan_0, chan_1, chan_2, output ready);
endinterface

interface kc3_res_if;
    logic valid;
    logic ready;
    logic [7:0] out_chan_0;
    logic [7:0] out_chan_1;
    logic [7:0] out_chan_2;
    logic [kc3_pkg::ROW_W-1:0] out_row;
    logic [kc3_pkg::COL_W-1:0] out_col;
    logic last_in_run;
    logic last_of_frame;
    modport source (output valid, out_chan_0, out_chan_1, out_chan_2, out_row, out_col,
                    last_in_run, last_of_frame, input ready);
    modport sink (input valid, out_chan_0, out_chan_1, out_chan_2, out_row, out_col,
                  last_in_run, last_of_frame, output ready);
endinterface

interface kc3_cfg_if;
    logic valid;
    logic ready;
    logic [2:0] index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/kc3_lane.sv
// One color lane: 3x3 multiply-accumulate, then an iterative divide and clamp.
// Depends on kc3_pkg.
module kc3_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [7:0]                  i_px [9],
    input  kc3_pkg::t_kernel            i_k,
    input  logic signed [kc3_pkg::KSUM_W-1:0] i_ksum,
    output logic                        o_done,
    output logic [7:0]                  o_val
);
    localparam int SW = kc3_pkg::SUM_W;

    // stage 1: products registered
    logic signed [16:0] r_prod [9];
    logic signed [16:0] n_prod [9];
    kc3_pkg::t_lane_ph r_ph, n_ph;
    logic n_done;
    logic [4:0] r_cnt;
    logic [SW-1:0] r_num, r_rem;
    logic [kc3_pkg::KSUM_W-1:0] r_den;
    logic r_neg, r_div0;
    logic signed [SW-1:0] r_sum;
    logic signed [SW-1:0] n_sum;
    logic [SW:0] trial;
    logic [SW-1:0] shifted;
    logic [7:0] r_val;

    function automatic logic [7:0] clamp(input logic signed [SW:0] v);
        if (v < 0) clamp = 8'd0;
        else if (v > $signed({{(SW-8){1'b0}}, kc3_pkg::CLAMP_MAX})) clamp = kc3_pkg::CLAMP_MAX;
        else clamp = v[7:0];
    endfunction

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            n_prod[i] = 17'(i_k[i] * $signed({1'b0, i_px[i]}));
        end
        n_sum = '0;
        for (int i = 0; i < 9; i++) begin
            n_sum = n_sum + SW'(r_prod[i]);
        end
        shifted = {r_rem[SW-2:0], r_num[SW-1]};
        trial = {1'b0, shifted} - (SW+1)'(r_den);
    end

    // phase sequencing
    always_comb begin
        n_ph = r_ph;
        n_done = 1'b0;
        if (i_start) begin
            n_ph = kc3_pkg::LANE_SUM;
        end else begin
            unique case (r_ph)
                kc3_pkg::LANE_IDLE: ;
                kc3_pkg::LANE_SUM: n_ph = kc3_pkg::LANE_SETUP;
                kc3_pkg::LANE_SETUP: n_ph = kc3_pkg::LANE_DIV;
                kc3_pkg::LANE_DIV: begin
                    if (r_div0 || r_cnt == '0) begin
                        n_ph = kc3_pkg::LANE_IDLE;
                        n_done = 1'b1;
                    end
                end
                default: n_ph = kc3_pkg::LANE_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= kc3_pkg::LANE_IDLE;
            o_done <= 1'b0;
        end else begin
            r_ph <= n_ph;
            o_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= n_prod;
        end
        if (r_ph == kc3_pkg::LANE_SUM) begin
            r_sum <= n_sum;
        end
        if (r_ph == kc3_pkg::LANE_SETUP) begin
            r_neg <= r_sum[SW-1] ^ i_ksum[kc3_pkg::KSUM_W-1];
            r_div0 <= (i_ksum == '0);
            r_num <= r_sum[SW-1] ? SW'(-r_sum) : r_sum;
            r_den <= i_ksum[kc3_pkg::KSUM_W-1] ? kc3_pkg::KSUM_W'(-i_ksum) : i_ksum;
            r_rem <= '0;
            r_cnt <= 5'(SW);
        end
        if (r_ph == kc3_pkg::LANE_DIV) begin
            if (r_div0) begin
                r_cnt <= '0;
                r_num <= r_sum;
            end else if (r_cnt != 0) begin
                r_num <= {r_num[SW-2:0], ~trial[SW]};
                r_rem <= trial[SW] ? shifted : trial[SW-1:0];
                r_cnt <= r_cnt - 5'd1;
            end
        end
        if (n_done) begin
            r_val <= clamp(r_div0 ? {r_sum[SW-1], r_sum} :
                (r_neg ? -$signed({1'b0, r_num}) : $signed({1'b0, r_num})));
        end
    end

    assign o_val = r_val;
endmodule

FILE: hdl/kc3_merge.sv
// Merges the three lane results and the position tag into one result register.
// Depends on kc3_pkg.
module kc3_merge (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_done,
    input  logic [7:0]     i_val [3],
    input  kc3_pkg::t_tag  i_tag,
    kc3_res_if.source      res,
    output logic           o_busy
);
    logic r_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_done) begin
            r_valid <= 1'b1;
            res.out_chan_0 <= i_val[0];
            res.out_chan_1 <= i_val[1];
            res.out_chan_2 <= i_val[2];
            res.out_row <= i_tag.row;
            res.out_col <= i_tag.col;
            res.last_in_run <= i_tag.last_in_run;
            res.last_of_frame <= i_tag.last_of_frame;
        end else if (res.ready) begin
            r_valid <= 1'b0;
        end
    end
    assign res.valid = r_valid;
    assign o_busy = r_valid;
endmodule

FILE: hdl/kernel_convolution_3x3_rgb.sv
// Top level of the 3x3 normalized RGB convolution: line stores, window,
// result sequencer. Depends on kc3_pkg, kc3_if, kc3_lane, kc3_merge.
//
// Channels: pix (sink) takes one 24-bit pixel per request in raster order;
// res (source) gives filtered pixels tagged with row and column; cfg (sink)
// writes kernel rows (0..2), width (3) and height (4); the user must write
// them only while idle, as the block itself does not enforce it.
// Each pixel gives 0..4 results for neighbors whose windows are complete:
// output lags one row and one column; last column and last row flush at once.
// Each result passes a product stage, an adder tree stage, divider setup,
// 20 restoring divide steps (none when the kernel sums to zero) and a
// done flag in each of the three color lanes (one per byte, each with its
// own divider), then the merge register and the handshake.
// A pixel is taken only when the previous one has delivered all results.
// Reset clears counters, window, kernel to identity, width 2048, height 1.
// Line stores are not cleared; entries read before written only feed
// neighbors outside the image, which are replaced by the center pixel.
// A stalled receiver holds the result register; the sequencer waits.
module kernel_convolution_3x3_rgb (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kc3_pix_if.sink   pix,
    kc3_res_if.source res,
    kc3_cfg_if.sink   cfg
);
    localparam int AW = $clog2(kc3_pkg::MAX_WIDTH);

    logic [23:0] r_ktop, r_kmid, r_kbot;
    logic [11:0] r_width;
    logic [12:0] r_height;
    logic [kc3_pkg::ROW_W-1:0] r_row;
    logic [kc3_pkg::COL_W-1:0] r_col;
    logic [23:0] r_win [9];
    logic [23:0] mem_old [kc3_pkg::MAX_WIDTH];
    logic [23:0] mem_new [kc3_pkg::MAX_WIDTH];
    logic [23:0] r_rd_old, r_rd_new, r_px;

    // sequencer: idle, memory read, emit results (window shifts on read)
    kc3_pkg::t_seq_st r_st, n_st;
    logic [2:0] r_slot;   // cs*2+rs bit pair, count to 4
    logic [2:0] n_slot;
    logic       pix_done;
    logic       r_lane_busy;
    logic [12:0] eff_w;
    logic [12:0] eff_h;
    logic [AW-1:0] addr;

    always_comb begin
        eff_w = (r_width == '0) ? 13'd1 :
                (13'(r_width) > 13'(kc3_pkg::MAX_WIDTH)) ? 13'(kc3_pkg::MAX_WIDTH) :
                13'(r_width);
        eff_h = (r_height == '0) ? 13'd1 :
                (r_height > 13'(kc3_pkg::HEIGHT_LIMIT)) ? 13'(kc3_pkg::HEIGHT_LIMIT) : r_height;
    end

    logic [12:0] cur_r, cur_c;
    assign cur_r = (13'(r_row) >= eff_h) ? eff_h - 13'd1 : 13'(r_row);
    assign cur_c = (13'(r_col) >= eff_w) ? eff_w - 13'd1 : 13'(r_col);
    assign addr = AW'(cur_c);

    logic last_row, last_col;
    assign last_row = (cur_r == eff_h - 13'd1);
    assign last_col = (cur_c == eff_w - 13'd1);

    logic pix_acc, cfg_acc;
    assign pix.ready = i_rst_n && (r_st == kc3_pkg::SEQ_IDLE);
    assign pix_acc = pix.valid && pix.ready;
    assign cfg.ready = i_rst_n;
    assign cfg_acc = cfg.valid && cfg.ready;

    // slot decode
    logic cs, rs, slot_ok;
    logic [12:0] sr, sc;
    assign cs = r_slot[1];
    assign rs = r_slot[0];
    always_comb begin
        slot_ok = (cs ? last_col : (cur_c != 0)) && (rs ? last_row : (cur_r != 0));
        sr = rs ? cur_r : cur_r - 13'd1;
        sc = cs ? cur_c : cur_c - 13'd1;
    end

    // next valid slot after this one, for last_in_run
    logic more;
    always_comb begin
        more = 1'b0;
        for (int s = 0; s < 4; s++) begin
            if (3'(s) > r_slot &&
                ((s[1] ? last_col : (cur_c != 0)) && (s[0] ? last_row : (cur_r != 0))))
                more = 1'b1;
        end
    end

    // window gather with edge replacement
    logic [23:0] gpx [9];
    logic [1:0] dr0, dc0;
    always_comb begin
        logic [23:0] ctr;
        logic signed [13:0] nr, nc;
        logic [1:0] wr, wc;
        dr0 = rs ? 2'd2 : 2'd1;
        dc0 = cs ? 2'd2 : 2'd1;
        ctr = r_win[4'(dr0) * 4'd3 + 4'(dc0)];
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                nr = $signed({1'b0, sr}) + 14'(a) - 14'sd1;
                nc = $signed({1'b0, sc}) + 14'(b) - 14'sd1;
                wr = dr0 + 2'(a) - 2'd1;
                wc = dc0 + 2'(b) - 2'd1;
                if (nr < 0 || nc < 0 || nr >= $signed({1'b0, eff_h}) ||
                    nc >= $signed({1'b0, eff_w}) || wr == 2'd3 || wc == 2'd3)
                    gpx[a*3+b] = ctr;
                else
                    gpx[a*3+b] = r_win[4'(wr) * 4'd3 + 4'(wc)];
            end
        end
    end

    kc3_pkg::t_kernel kern;
    logic signed [kc3_pkg::KSUM_W-1:0] ksum;
    always_comb begin
        for (int b = 0; b < 3; b++) begin
            kern[b] = r_ktop[8*b +: 8];
            kern[3+b] = r_kmid[8*b +: 8];
            kern[6+b] = r_kbot[8*b +: 8];
        end
        ksum = '0;
        for (int i = 0; i < 9; i++) ksum = ksum + kc3_pkg::KSUM_W'(kern[i]);
    end

    logic start;
    logic [2:0] done;
    logic [7:0] vals [3];
    logic [7:0] lpx [3][9];
    logic merge_busy;
    kc3_pkg::t_tag r_tag;

    assign start = (r_st == kc3_pkg::SEQ_EMIT) && slot_ok && !r_lane_busy && !merge_busy &&
                   (r_slot < 3'd4);

    // next state: walk the four slots, leave once the last result is taken
    always_comb begin
        n_st = r_st;
        n_slot = r_slot;
        pix_done = 1'b0;
        unique case (r_st)
            kc3_pkg::SEQ_IDLE: if (pix_acc) n_st = kc3_pkg::SEQ_READ;
            kc3_pkg::SEQ_READ: begin
                n_slot = '0;
                n_st = kc3_pkg::SEQ_EMIT;
            end
            kc3_pkg::SEQ_EMIT: begin
                if (r_slot == 3'd4) begin
                    if (!r_lane_busy && !merge_busy) begin
                        n_st = kc3_pkg::SEQ_IDLE;
                        pix_done = 1'b1;
                    end
                end else if (!slot_ok || start) begin
                    n_slot = r_slot + 3'd1;
                end
            end
            default: n_st = kc3_pkg::SEQ_IDLE;
        endcase
    end

    generate
        for (genvar p = 0; p < 3; p++) begin : g_lane
            always_comb begin
                for (int i = 0; i < 9; i++) lpx[p][i] = gpx[i][8*p +: 8];
            end
            kc3_lane u_lane (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
                .i_px(lpx[p]), .i_k(kern), .i_ksum(ksum),
                .o_done(done[p]), .o_val(vals[p])
            );
        end
    endgenerate

    kc3_merge u_merge (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_done(done[0]), .i_val(vals),
        .i_tag(r_tag), .res(res), .o_busy(merge_busy)
    );

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_rd_old <= mem_old[addr];
            r_rd_new <= mem_new[addr];
            r_px <= {pix.chan_2, pix.chan_1, pix.chan_0};
        end
        if (r_st == kc3_pkg::SEQ_READ) begin
            mem_old[addr] <= r_rd_new;
            mem_new[addr] <= r_px;
        end
        if (start) begin
            r_tag.row <= sr[kc3_pkg::ROW_W-1:0];
            r_tag.col <= sc[kc3_pkg::COL_W-1:0];
            r_tag.last_in_run <= !more;
            r_tag.last_of_frame <= (sr == eff_h - 13'd1) && (sc == eff_w - 13'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ktop <= '0;
            r_kmid <= 24'd256;
            r_kbot <= '0;
            r_width <= 12'd2048;
            r_height <= 13'd1;
            r_row <= '0;
            r_col <= '0;
            r_st <= kc3_pkg::SEQ_IDLE;
            r_slot <= '0;
            r_lane_busy <= 1'b0;
            for (int i = 0; i < 9; i++) r_win[i] <= '0;
        end else begin
            r_st <= n_st;
            r_slot <= n_slot;
            if (cfg_acc) begin
                unique case (cfg.index)
                    kc3_pkg::REG_KTOP: r_ktop <= cfg.data;
                    kc3_pkg::REG_KMID: r_kmid <= cfg.data;
                    kc3_pkg::REG_KBOT: r_kbot <= cfg.data;
                    kc3_pkg::REG_WIDTH: begin
                        r_width <= cfg.data[11:0];
                        r_row <= '0;
                        r_col <= '0;
                    end
                    kc3_pkg::REG_HEIGHT: begin
                        r_height <= cfg.data[12:0];
                        r_row <= '0;
                        r_col <= '0;
                    end
                    default: ;
                endcase
            end
            if (start) r_lane_busy <= 1'b1;
            else if (done[0]) r_lane_busy <= 1'b0;
            if (r_st == kc3_pkg::SEQ_READ) begin
                for (int i = 0; i < 3; i++) begin
                    r_win[i*3] <= r_win[i*3+1];
                    r_win[i*3+1] <= r_win[i*3+2];
                end
                r_win[2] <= r_rd_old;
                r_win[5] <= r_rd_new;
                r_win[8] <= r_px;
            end
            // advance raster position once all results are out
            if (pix_done) begin
                if (cur_c + 13'd1 >= eff_w) begin
                    r_col <= '0;
                    r_row <= (cur_r + 13'd1 >= eff_h) ? '0 :
                             kc3_pkg::ROW_W'(cur_r + 13'd1);
                end else begin
                    r_col <= kc3_pkg::COL_W'(cur_c + 13'd1);
                    r_row <= kc3_pkg::ROW_W'(cur_r);
                end
            end
        end
    end

    a_one_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> !start) else $error("lane restarted while busy");
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != kc3_pkg::SEQ_IDLE) |-> !pix.ready) else $error("pixel taken mid work");
    a_lanes_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done[0] |-> (done[1] && done[2])) else $error("lanes out of step");
endmodule

FILE: sim/kernel_convolution_3x3_rgb_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for kernel_convolution_3x3_rgb: drives pixel frames,
// predicts every filtered pixel and compares it. Depends on kc3_pkg, kc3_if, the RTL.
module kernel_convolution_3x3_rgb_tb;

    localparam int LINE_DEPTH   = kc3_pkg::MAX_WIDTH;
    localparam int FLUSH_CYCLES = 120;   // a request with four results, plus margin
    localparam int STALL_LIMIT  = 3000;  // cycles without any handshake on any channel
    localparam int LONG_HOLD    = 400;   // receiver hold-off that backs up the block
    localparam int RANDOM_ITEMS = 175;
    localparam int TAIL_ITEMS   = 25;
    localparam logic [2:0] REG_SPARE_LO = 3'd5;  // indexes past REG_HEIGHT are ignored
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    // One filtered pixel as it leaves the block
    typedef struct {
        logic [7:0]                chan_0;
        logic [7:0]                chan_1;
        logic [7:0]                chan_2;
        logic [kc3_pkg::ROW_W-1:0] row;
        logic [kc3_pkg::COL_W-1:0] col;
        logic                      last_in_run;
        logic                      last_of_frame;
    } t_filt_px;

    logic i_clk;
    logic i_rst_n;

    kc3_pix_if pix_ch ();
    kc3_res_if res_ch ();
    kc3_cfg_if cfg_ch ();

    kernel_convolution_3x3_rgb u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .pix     (pix_ch),
        .res     (res_ch),
        .cfg     (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared run state
    // ------------------------------------------------------------------
    t_filt_px filtered_q[$];   // filtered pixels still owed by the block
    int  errors          = 0;
    int  pixels_sent     = 0;
    int  pixels_checked  = 0;
    int  settings_used   = 0;
    bit  idle_en         = 1'b1;  // random bursts of idling on both sides
    bit  long_hold_req   = 1'b0;

    // ------------------------------------------------------------------
    // Predictor state: register copies, line stores, 3x3 window, position
    // ------------------------------------------------------------------
    logic [23:0] kern_row [3];
    int          width_reg;
    int          height_reg;
    logic [23:0] older_line [LINE_DEPTH];
    logic [23:0] newer_line [LINE_DEPTH];
    logic [23:0] win [9];
    int          row_at;
    int          col_at;

    function automatic void model_reset();
        kern_row[0] = 24'h000000;
        kern_row[1] = 24'h000100;  // identity
        kern_row[2] = 24'h000000;
        width_reg   = 2048;
        height_reg  = 1;
        // unwritten entries only feed out-of-image neighbors, so zero is fine
        foreach (older_line[i]) older_line[i] = '0;
        foreach (newer_line[i]) newer_line[i] = '0;
        foreach (win[i]) win[i] = '0;
        row_at = 0;
        col_at = 0;
    endfunction

    function automatic void model_write_reg(logic [2:0] idx, logic [23:0] data);
        case (idx)
            kc3_pkg::REG_KTOP:   kern_row[0] = data;
            kc3_pkg::REG_KMID:   kern_row[1] = data;
            kc3_pkg::REG_KBOT:   kern_row[2] = data;
            kc3_pkg::REG_WIDTH: begin
                width_reg = data[11:0];
                row_at = 0;
                col_at = 0;
            end
            kc3_pkg::REG_HEIGHT: begin
                height_reg = data[12:0];
                row_at = 0;
                col_at = 0;
            end
            default: ;
        endcase
    endfunction

    function automatic int coef_at(int a, int b);
        logic signed [7:0] v;
        v = kern_row[a][8*b +: 8];
        return int'(v);
    endfunction

    // Filters pixel (R,C); (dr0,dc0) is its place inside the window
    function automatic logic [23:0] filter_at(int R, int C, int dr0, int dc0,
                                              int W, int H, int ksum);
        logic [23:0] outp;
        logic [23:0] centre;
        logic [23:0] px;
        int sum, wr, wc;
        outp = '0;
        centre = win[dr0*3 + dc0];
        for (int p = 0; p < kc3_pkg::CHANS; p++) begin
            sum = 0;
            for (int a = -1; a <= 1; a++) begin
                for (int b = -1; b <= 1; b++) begin
                    wr = dr0 + a;
                    wc = dc0 + b;
                    if (R + a < 0 || C + b < 0 || R + a >= H || C + b >= W)
                        px = centre;  // outside the image: use the centre pixel
                    else if (wr < 0 || wr > 2 || wc < 0 || wc > 2)
                        px = centre;
                    else
                        px = win[wr*3 + wc];
                    sum += coef_at(a + 1, b + 1) * int'(px[8*p +: 8]);
                end
            end
            if (ksum != 0) sum = sum / ksum;   // truncates toward zero
            if (sum > 255) sum = 255;
            if (sum < 0) sum = 0;
            outp[8*p +: 8] = sum[7:0];
        end
        return outp;
    endfunction

    // Takes one accepted pixel and queues the filtered pixels it releases
    function automatic void convolve_pixel(logic [23:0] px);
        int W, H, r, c, ksum, n_out, R, C;
        logic [23:0] o, n, v;
        t_filt_px e;
        W = (width_reg == 0) ? 1 : (width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg;
        H = (height_reg == 0) ? 1 :
            (height_reg > kc3_pkg::HEIGHT_LIMIT) ? kc3_pkg::HEIGHT_LIMIT : height_reg;
        r = (row_at >= H) ? H - 1 : row_at;
        c = (col_at >= W) ? W - 1 : col_at;
        o = older_line[c];
        n = newer_line[c];
        older_line[c] = n;
        newer_line[c] = px;
        for (int i = 0; i < 3; i++) begin
            win[i*3]     = win[i*3 + 1];
            win[i*3 + 1] = win[i*3 + 2];
        end
        win[2] = o;
        win[5] = n;
        win[8] = px;
        ksum = 0;
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                ksum += coef_at(a, b);
        n_out = 0;
        // column c-1 first, then c on the last column; rows likewise
        for (int cs = 0; cs < 2; cs++) begin
            if ((cs == 0 && c >= 1) || (cs == 1 && c == W - 1)) begin
                C = (cs == 0) ? c - 1 : c;
                for (int rs = 0; rs < 2; rs++) begin
                    if ((rs == 0 && r >= 1) || (rs == 1 && r == H - 1)) begin
                        R = (rs == 0) ? r - 1 : r;
                        v = filter_at(R, C, R - r + 2, C - c + 2, W, H, ksum);
                        e.chan_0 = v[7:0];
                        e.chan_1 = v[15:8];
                        e.chan_2 = v[23:16];
                        e.row = R[kc3_pkg::ROW_W-1:0];
                        e.col = C[kc3_pkg::COL_W-1:0];
                        e.last_in_run = 1'b0;
                        e.last_of_frame = (R == H - 1 && C == W - 1);
                        filtered_q.push_back(e);
                        n_out++;
                    end
                end
            end
        end
        if (n_out > 0) filtered_q[filtered_q.size() - 1].last_in_run = 1'b1;
        c++;
        if (c >= W) begin
            c = 0;
            r++;
            if (r >= H) r = 0;
        end
        row_at = r;
        col_at = c;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_filt_px e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (filtered_q.size() == 0) begin
                $error("filtered pixel (%0d,%0d) with none outstanding",
                       res_ch.out_row, res_ch.out_col);
                errors++;
            end else begin
                e = filtered_q.pop_front();
                check_field("out_chan_0", e.chan_0, res_ch.out_chan_0);
                check_field("out_chan_1", e.chan_1, res_ch.out_chan_1);
                check_field("out_chan_2", e.chan_2, res_ch.out_chan_2);
                check_field("out_row", e.row, res_ch.out_row);
                check_field("out_col", e.col, res_ch.out_col);
                check_field("last_in_run", e.last_in_run, res_ch.last_in_run);
                check_field("last_of_frame", e.last_of_frame, res_ch.last_of_frame);
                pixels_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run when nothing moves for too long
    // ------------------------------------------------------------------
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // One pixel request; valid stays high afterwards for back-to-back pixels
    task automatic send_pixel(logic [23:0] px);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        pix_ch.valid  <= 1'b1;
        pix_ch.chan_0 <= px[7:0];
        pix_ch.chan_1 <= px[15:8];
        pix_ch.chan_2 <= px[23:16];
        do @(posedge i_clk); while (!pix_ch.ready);
        convolve_pixel(px);
        pixels_sent++;
    endtask

    // Sender goes quiet until every filtered pixel is back; pixels that
    // release nothing may still be in flight, hence the extra cycles
    task automatic wait_drain();
        pix_ch.valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (FLUSH_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        model_write_reg(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_kernel(logic [23:0] top, logic [23:0] mid, logic [23:0] bot);
        write_reg(kc3_pkg::REG_KTOP, top);
        write_reg(kc3_pkg::REG_KMID, mid);
        write_reg(kc3_pkg::REG_KBOT, bot);
        settings_used++;
    endtask

    task automatic set_geometry(logic [23:0] w, logic [23:0] h);
        write_reg(kc3_pkg::REG_WIDTH, w);
        write_reg(kc3_pkg::REG_HEIGHT, h);
        settings_used++;
    endtask

    function automatic logic [23:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    // Kernel row: full-range bytes, or small weights that keep sums in range
    function automatic logic [23:0] rand_kernel_row(bit full);
        logic [23:0] row;
        logic signed [7:0] k;
        for (int b = 0; b < 3; b++) begin
            k = full ? 8'($urandom) : 8'($urandom_range(0, 5) - 2);
            row[8*b +: 8] = k;
        end
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_identity();
        set_geometry(24'd2, 24'd2);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'hAA55AA);
        send_pixel(24'h55AA55);
        wait_drain();
    endtask

    // Largest positive and negative weights, and a kernel summing to zero
    // (no division then)
    task automatic test_kernel_extremes();
        set_kernel(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
        repeat (4) send_pixel(rand_pixel());
        wait_drain();
        set_kernel(24'h808080, 24'h808080, 24'h808080);
        repeat (4) send_pixel(rand_pixel());
        wait_drain();
        set_kernel(24'h0001FF, 24'h000000, 24'h000000);
        repeat (4) send_pixel(rand_pixel());
        wait_drain();
    endtask

    // Zero and oversize geometry, ignored register indexes, single row/column
    task automatic test_geometry_edges();
        set_kernel(24'h010201, 24'h020402, 24'h010201);
        set_geometry(24'd0, 24'd0);            // both act as 1
        for (logic [3:0] i = REG_SPARE_LO; i <= REG_SPARE_HI; i++)
            write_reg(i[2:0], 24'h000000);     // must change nothing
        send_pixel(24'h123456);
        send_pixel(24'hFEDCBA);
        wait_drain();
        set_geometry(24'd1, 24'd3);
        repeat (3) send_pixel(rand_pixel());
        wait_drain();
        set_geometry(24'd4095, 24'd1);         // width saturates to the maximum
        repeat (2) send_pixel(rand_pixel());
        wait_drain();
        set_geometry(24'd2, 24'd8191);         // height saturates
        repeat (2) send_pixel(rand_pixel());   // row 0 of a tall frame: no output yet
        wait_drain();
        set_geometry(24'd2048, 24'd2);
        repeat (2) send_pixel(rand_pixel());
        wait_drain();
    endtask

    // Whole frames with random content, some cut short or run twice over
    task automatic test_random_frames();
        int w, h, n, phase;
        phase = 0;
        while (pixels_sent < RANDOM_ITEMS) begin
            wait_drain();
            if ($urandom_range(0, 3) == 0)
                set_kernel(rand_kernel_row(1), rand_kernel_row(1), rand_kernel_row(1));
            else
                set_kernel(rand_kernel_row(0), rand_kernel_row(0), rand_kernel_row(0));
            if ($urandom_range(0, 7) == 0) begin
                w = $urandom_range(9, 40);
                h = $urandom_range(1, 2);
            end else begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 6);
            end
            set_geometry(24'(w), 24'(h));
            n = w * h;
            case ($urandom_range(0, 5))
                0: n = $urandom_range(1, n);   // broken frame, restarted by the next setup
                1: n = 2 * n;                  // counters wrap into a second frame
                default: ;
            endcase
            if (phase == 2) long_hold_req = 1'b1;
            for (int i = 0; i < n; i++) begin
                // once: sender waits for every result mid-frame
                if (phase == 4 && i == n / 2) wait_drain();
                send_pixel(rand_pixel());
            end
            phase++;
        end
        wait_drain();
    endtask

    // Last stretch at full rate on both sides
    task automatic test_full_rate();
        idle_en = 1'b0;
        set_kernel(24'h01FF01, 24'hFF08FF, 24'h01FF01);
        set_geometry(24'd5, 24'd5);
        repeat (TAIL_ITEMS) send_pixel(rand_pixel());
        wait_drain();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n      <= 1'b0;
        pix_ch.valid <= 1'b0;
        pix_ch.chan_0 <= '0;
        pix_ch.chan_1 <= '0;
        pix_ch.chan_2 <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data  <= '0;
        model_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_identity();
        test_kernel_extremes();
        test_geometry_edges();
        test_random_frames();
        test_full_rate();

        if (filtered_q.size() != 0) begin
            $error("%0d filtered pixels never came out", filtered_q.size());
            errors++;
        end
        $display("Ran %0d pixels through %0d kernel/geometry setups, %0d outputs checked.",
                 pixels_sent, settings_used, pixels_checked);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
